// ===== hdl/poi_pkg.sv =====
`default_nettype none

package poi_pkg;

  localparam int HEADING_BITS_DEF = 24;
  localparam int CORDIC_STEPS_DEF = 16;

  // arctangent table depth and its index width
  localparam int ATAN_LEN   = 24;
  localparam int ATAN_IDX_W = $clog2(ATAN_LEN);

  // cordic datapath width, Q2.30 with headroom
  localparam int CORDIC_W = 34;
  localparam logic signed [CORDIC_W-1:0] CORDIC_START = 34'sd652032874;

  // shared multiplier operand widths
  localparam int MUL_A_W = 35;
  localparam int MUL_B_W = 18;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // round(2^32 / (4 pi)), split into two 15 bit halves for the multiplier
  localparam longint INV_4PI_Q32 = 341782638;
  localparam logic [14:0] INV_4PI_LO = 15'(INV_4PI_Q32 % 32768);
  localparam logic [14:0] INV_4PI_HI = 15'(INV_4PI_Q32 / 32768);

  localparam logic [15:0]        STEP_TIME_RST = 16'd2621;
  localparam logic signed [31:0] ALTITUDE_RST  = 32'sd131072;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_TIME = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ALTITUDE  = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_ROT1,
    ST_P0, ST_P1, ST_P2, ST_P3, ST_P4, ST_P5, ST_P6, ST_P7,
    ST_H0, ST_H1, ST_H2, ST_H3, ST_H4, ST_H5, ST_H6,
    ST_ROT2,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic signed [15:0] speed_forward;
    logic signed [15:0] speed_lateral;
    logic signed [15:0] yaw_rate;
  } in_t;

  typedef struct packed {
    logic signed [31:0] position_x;
    logic signed [31:0] position_y;
    logic signed [31:0] position_z;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
  } out_t;

  typedef struct packed {
    logic        start;
    logic [31:0] phase;
  } cordic_req_t;

  typedef struct packed {
    logic                       done;
    logic signed [CORDIC_W-1:0] sin;
    logic signed [CORDIC_W-1:0] cos;
  } cordic_rsp_t;

  // arctangent of 2^-i in 32 bit turns, truncated
  function automatic logic [31:0] atan_turn(input logic [ATAN_IDX_W-1:0] idx);
    logic [31:0] r;
    case (idx)
      5'd0:    r = 32'h20000000;
      5'd1:    r = 32'h12E4051E;
      5'd2:    r = 32'h09FB385B;
      5'd3:    r = 32'h051111D4;
      5'd4:    r = 32'h028B0D43;
      5'd5:    r = 32'h0145D7E1;
      5'd6:    r = 32'h00A2F61E;
      5'd7:    r = 32'h00517C55;
      5'd8:    r = 32'h0028BE53;
      5'd9:    r = 32'h00145F2F;
      5'd10:   r = 32'h000A2F98;
      5'd11:   r = 32'h000517CC;
      5'd12:   r = 32'h00028BE6;
      5'd13:   r = 32'h000145F3;
      5'd14:   r = 32'h0000A2F9;
      5'd15:   r = 32'h0000517C;
      5'd16:   r = 32'h000028BE;
      5'd17:   r = 32'h0000145F;
      5'd18:   r = 32'h00000A2F;
      5'd19:   r = 32'h00000517;
      5'd20:   r = 32'h0000028B;
      5'd21:   r = 32'h00000145;
      5'd22:   r = 32'h000000A2;
      5'd23:   r = 32'h00000051;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/poi_mul.sv =====
`default_nettype none

module poi_mul (
  input  wire logic                                  clk,
  input  wire logic signed [poi_pkg::MUL_A_W-1:0]    a,
  input  wire logic signed [poi_pkg::MUL_B_W-1:0]    b,
  output logic signed      [poi_pkg::MUL_P_W-1:0]    prod
);

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

`default_nettype wire

// ===== hdl/poi_cordic.sv =====
`default_nettype none

module poi_cordic #(
  parameter int STEPS = poi_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire poi_pkg::cordic_req_t req,
  output poi_pkg::cordic_rsp_t      rsp
);

  localparam int W     = poi_pkg::CORDIC_W;
  localparam int CNT_W = $clog2(STEPS);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(STEPS - 1);

  logic signed [W-1:0] x;
  logic signed [W-1:0] y;
  logic signed [W-1:0] z;
  logic [CNT_W-1:0]    cnt;
  logic                flip;
  logic                busy;
  logic                done;

  logic signed [W-1:0] xs;
  logic signed [W-1:0] ys;
  logic signed [W-1:0] at;
  logic signed [W-1:0] x_next;
  logic signed [W-1:0] y_next;
  logic signed [W-1:0] z_next;
  logic [31:0]         start_phase;

  always_comb begin
    xs = x >>> cnt;
    ys = y >>> cnt;
    at = W'(poi_pkg::atan_turn(poi_pkg::ATAN_IDX_W'(cnt)));
    if (z[W-1]) begin
      x_next = x + ys;
      y_next = y - xs;
      z_next = z + at;
    end else begin
      x_next = x - ys;
      y_next = y + xs;
      z_next = z - at;
    end
    // second and third quadrants are turned by pi first
    start_phase = (req.phase[31] ^ req.phase[30]) ?
                  {~req.phase[31], req.phase[30:0]} : req.phase;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && !req.start && (cnt == LAST);
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      x    <= poi_pkg::CORDIC_START;
      y    <= '0;
      z    <= W'($signed(start_phase));
      flip <= req.phase[31] ^ req.phase[30];
    end else if (busy) begin
      x <= x_next;
      y <= y_next;
      z <= z_next;
    end
  end

  assign rsp.done = done;
  assign rsp.sin  = flip ? -y : y;
  assign rsp.cos  = flip ? -x : x;

endmodule

`default_nettype wire

// ===== hdl/planar_odometry_integrator.sv =====
`default_nettype none

// Planar dead-reckoning integrator. Each velocity command (forward and lateral
// speed in Q8.8 m/s, yaw rate in Q4.12 rad/s) is rotated by the current
// heading, scaled by step_time and added to the saturating Q16.16 x and y
// positions; the heading (one 4*pi wrap over 2^HEADING_BITS codes) then
// advances by step_time * yaw_rate. Each command yields one beat with x, y,
// the altitude register and the yaw quaternion (z = sin, w = cos of half the
// new heading, Q1.14). For each command an iterative CORDIC runs once on the
// old heading and once on half the new one, and a single 35x18 multiplier is
// stepped through the eleven products in between. in_ready is high only while
// the sequencer is idle; the result sits in an output register, so the next
// command is taken while a result still waits on out_ready.
module planar_odometry_integrator #(
  parameter int HEADING_BITS = poi_pkg::HEADING_BITS_DEF,
  parameter int CORDIC_STEPS = poi_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire poi_pkg::in_t                     in_data,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output poi_pkg::out_t                         out_data,
  input  wire logic                             cfg_we,
  input  wire logic [poi_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [31:0]                      cfg_data
);

  localparam int CW  = poi_pkg::CORDIC_W;
  localparam int AW  = poi_pkg::MUL_A_W;
  localparam int BW  = poi_pkg::MUL_B_W;
  localparam int PW  = poi_pkg::MUL_P_W;
  localparam int SH  = 60 - HEADING_BITS;
  localparam int RW  = (HEADING_BITS > 26) ? HEADING_BITS : 26;
  localparam int QW  = CW - 16;

  poi_pkg::state_t state;
  poi_pkg::state_t state_next;

  // configuration and pose
  logic [15:0]             step_time;
  logic signed [31:0]      altitude;
  logic signed [31:0]      pos_x;
  logic signed [31:0]      pos_y;
  logic [HEADING_BITS-1:0] heading;

  // working registers
  logic signed [15:0]    vx;
  logic signed [15:0]    vy;
  logic signed [15:0]    vw;
  logic signed [CW-1:0]  sn;
  logic signed [CW-1:0]  cs;
  logic                  axis;
  logic signed [63:0]    acc;
  logic signed [47:0]    tmp;
  logic signed [31:0]    hrate;
  logic signed [RW-1:0]  rnd;

  logic signed [AW-1:0]  mul_a;
  logic signed [BW-1:0]  mul_b;
  logic signed [PW-1:0]  prod;

  poi_pkg::cordic_req_t  creq;
  poi_pkg::cordic_rsp_t  crsp;

  logic                  load;
  logic [32:0]           head_ext;
  logic signed [63:0]    round_half;
  logic signed [63:0]    round_sum;
  logic signed [32:0]    pos_sum;
  logic signed [31:0]    pos_sat;

  poi_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  poi_cordic #(
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk (clk),
    .rst (rst),
    .req (creq),
    .rsp (crsp)
  );

  // round half away from zero: add half, less one for negative values
  function automatic logic signed [15:0] quat_q14(input logic signed [CW-1:0] v);
    logic signed [CW-1:0] s;
    logic signed [QW-1:0] r;
    s = v + CW'(32768) - CW'(v[CW-1]);
    r = QW'(s >>> 16);
    if (r > QW'(16384)) begin
      return 16'sd16384;
    end else if (r < -QW'(16384)) begin
      return -16'sd16384;
    end
    return 16'(r);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= poi_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    load       = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    head_ext   = 33'(heading);
    creq.start = 1'b0;
    creq.phase = 32'(head_ext << (33 - HEADING_BITS));
    case (state)
      poi_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          creq.start = 1'b1;
          state_next = poi_pkg::ST_ROT1;
        end
      end
      poi_pkg::ST_ROT1: begin
        if (crsp.done) begin
          state_next = poi_pkg::ST_P0;
        end
      end
      poi_pkg::ST_P0: begin
        mul_a      = AW'(axis ? sn : cs);
        mul_b      = BW'(vx);
        state_next = poi_pkg::ST_P1;
      end
      poi_pkg::ST_P1: begin
        mul_a      = AW'(axis ? cs : sn);
        mul_b      = BW'(vy);
        state_next = poi_pkg::ST_P2;
      end
      poi_pkg::ST_P2: begin
        state_next = poi_pkg::ST_P3;
      end
      poi_pkg::ST_P3: begin
        // low half of the rotated sum times step_time
        mul_a      = AW'(acc[23:0]);
        mul_b      = BW'(step_time);
        state_next = poi_pkg::ST_P4;
      end
      poi_pkg::ST_P4: begin
        mul_a      = AW'($signed(acc[47:24]));
        mul_b      = BW'(step_time);
        state_next = poi_pkg::ST_P5;
      end
      poi_pkg::ST_P5: begin
        state_next = poi_pkg::ST_P6;
      end
      poi_pkg::ST_P6: begin
        state_next = poi_pkg::ST_P7;
      end
      poi_pkg::ST_P7: begin
        state_next = axis ? poi_pkg::ST_H0 : poi_pkg::ST_P0;
      end
      poi_pkg::ST_H0: begin
        mul_a      = AW'(step_time);
        mul_b      = BW'(vw);
        state_next = poi_pkg::ST_H1;
      end
      poi_pkg::ST_H1: begin
        mul_a      = AW'($signed(prod[31:0]));
        mul_b      = BW'(poi_pkg::INV_4PI_LO);
        state_next = poi_pkg::ST_H2;
      end
      poi_pkg::ST_H2: begin
        mul_a      = AW'(hrate);
        mul_b      = BW'(poi_pkg::INV_4PI_HI);
        state_next = poi_pkg::ST_H3;
      end
      poi_pkg::ST_H3: begin
        state_next = poi_pkg::ST_H4;
      end
      poi_pkg::ST_H4: begin
        state_next = poi_pkg::ST_H5;
      end
      poi_pkg::ST_H5: begin
        state_next = poi_pkg::ST_H6;
      end
      poi_pkg::ST_H6: begin
        // half of the new heading
        creq.start = 1'b1;
        creq.phase = 32'(head_ext << (32 - HEADING_BITS));
        state_next = poi_pkg::ST_ROT2;
      end
      poi_pkg::ST_ROT2: begin
        if (crsp.done) begin
          state_next = poi_pkg::ST_FIN;
        end
      end
      poi_pkg::ST_FIN: begin
        if (!out_valid || out_ready) begin
          load       = 1'b1;
          state_next = poi_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = poi_pkg::ST_IDLE;
      end
    endcase
  end

  // shared rounder and position saturation
  always_comb begin
    round_half = (state == poi_pkg::ST_P6) ? (64'sd1 <<< 37) : (64'sd1 <<< (SH - 1));
    round_sum  = acc + round_half - 64'(acc[63]);
    pos_sum    = 33'(axis ? pos_y : pos_x) + 33'($signed(rnd[25:0]));
    if (pos_sum[32] != pos_sum[31]) begin
      pos_sat = pos_sum[32] ? 32'sh80000000 : 32'sh7FFFFFFF;
    end else begin
      pos_sat = pos_sum[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_time <= poi_pkg::STEP_TIME_RST;
      altitude  <= poi_pkg::ALTITUDE_RST;
      pos_x     <= '0;
      pos_y     <= '0;
      heading   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          poi_pkg::REG_STEP_TIME: step_time <= cfg_data[15:0];
          poi_pkg::REG_ALTITUDE:  altitude  <= $signed(cfg_data);
          default: ;
        endcase
      end
      if (state == poi_pkg::ST_P7) begin
        if (axis) begin
          pos_y <= pos_sat;
        end else begin
          pos_x <= pos_sat;
        end
      end
      if (state == poi_pkg::ST_H5) begin
        heading <= heading + rnd[HEADING_BITS-1:0];
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      poi_pkg::ST_IDLE: begin
        if (in_valid) begin
          vx   <= in_data.speed_forward;
          vy   <= in_data.speed_lateral;
          vw   <= in_data.yaw_rate;
          axis <= 1'b0;
        end
      end
      poi_pkg::ST_ROT1, poi_pkg::ST_ROT2: begin
        if (crsp.done) begin
          sn <= crsp.sin;
          cs <= crsp.cos;
        end
      end
      poi_pkg::ST_P1: acc <= 64'(prod);
      poi_pkg::ST_P2: acc <= axis ? acc + 64'(prod) : acc - 64'(prod);
      poi_pkg::ST_P4: tmp <= prod[47:0];
      poi_pkg::ST_P5: acc <= (64'(prod) <<< 24) + 64'(tmp);
      poi_pkg::ST_P6: rnd <= RW'(round_sum >>> 38);
      poi_pkg::ST_P7: axis <= ~axis;
      poi_pkg::ST_H1: hrate <= $signed(prod[31:0]);
      poi_pkg::ST_H2: tmp <= prod[47:0];
      poi_pkg::ST_H3: acc <= (64'(prod) <<< 15) + 64'(tmp);
      poi_pkg::ST_H4: rnd <= RW'(round_sum >>> SH);
      poi_pkg::ST_FIN: begin
        if (load) begin
          out_data.position_x <= pos_x;
          out_data.position_y <= pos_y;
          out_data.position_z <= altitude;
          out_data.quat_z     <= quat_q14(sn);
          out_data.quat_w     <= quat_q14(cs);
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import poi_pkg::*;

  localparam int HEADING_W   = HEADING_BITS_DEF;
  localparam int ROT_STEPS   = CORDIC_STEPS_DEF;
  localparam int QUIET_LIMIT = 4000;
  localparam longint POS_MAX = 64'sd2147483647;
  localparam longint POS_MIN = -64'sd2147483648;
  localparam longint TURN_SCALE = 64'sd341782638;
  localparam longint GAIN_START = 64'sd652032874;

  // arctangent of 2^-i in 32 bit turns, truncated
  localparam logic [31:0] ARCTAN_TURNS [16] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_STEP_TIME;
  logic [31:0] cfg_data = '0;

  planar_odometry_integrator dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // pose tracker state and its copy of the registers
  logic [15:0]          step_q16   = STEP_TIME_RST;
  logic signed [31:0]   height_q16 = ALTITUDE_RST;
  longint               x_acc = 0;
  longint               y_acc = 0;
  logic [HEADING_W-1:0] heading = '0;

  out_t pose_expected [$];
  out_t want;
  int   failures = 0;
  int   send_gap_pct = 0;
  int   recv_stall_pct = 0;
  int   quiet_cycles = 0;

  function automatic longint round_shift(longint v, int s);
    longint half;
    half = longint'(1) << (s - 1);
    if (v >= 0) return (v + half) >>> s;
    return -((-v + half) >>> s);
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // phase in 32 bit turns; sine and cosine come back in Q2.30
  function automatic void cordic_sincos(input logic [31:0] phase,
                                        output longint sn, output longint cs);
    logic [31:0] p;
    logic flip;
    longint x, y, z, xs, ys;
    flip = (phase[31:30] == 2'd1) || (phase[31:30] == 2'd2);
    p = flip ? phase + 32'h8000_0000 : phase;
    z = $signed(p);
    x = GAIN_START;
    y = 0;
    for (int i = 0; i < ROT_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys;
        y = y + xs;
        z = z - longint'(ARCTAN_TURNS[i]);
      end else begin
        x = x + ys;
        y = y - xs;
        z = z + longint'(ARCTAN_TURNS[i]);
      end
    end
    sn = flip ? -y : y;
    cs = flip ? -x : x;
  endfunction

  function automatic out_t advance_pose(in_t cmd);
    longint vx, vy, vw, st, sn, cs, delta, qz, qw;
    logic [63:0] wide;
    out_t res;
    vx = cmd.speed_forward;
    vy = cmd.speed_lateral;
    vw = cmd.yaw_rate;
    st = {48'd0, step_q16};
    // body velocity turned by the heading held before this command
    wide = 64'(heading) << (33 - HEADING_W);
    cordic_sincos(wide[31:0], sn, cs);
    x_acc = clamp(x_acc + round_shift((vx * cs - vy * sn) * st, 38), POS_MIN, POS_MAX);
    y_acc = clamp(y_acc + round_shift((vx * sn + vy * cs) * st, 38), POS_MIN, POS_MAX);
    delta = round_shift(st * vw * TURN_SCALE, 60 - HEADING_W);
    heading = heading + delta[HEADING_W-1:0];
    // half angle of the new heading for the quaternion
    wide = 64'(heading) << (32 - HEADING_W);
    cordic_sincos(wide[31:0], sn, cs);
    qz = clamp(round_shift(sn, 16), -16384, 16384);
    qw = clamp(round_shift(cs, 16), -16384, 16384);
    res.position_x = x_acc[31:0];
    res.position_y = y_acc[31:0];
    res.position_z = height_q16;
    res.quat_z = qz[15:0];
    res.quat_w = qw[15:0];
    return res;
  endfunction

  // result side: random back-pressure and comparison against the oldest pose
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
    if (!rst && out_valid && out_ready) begin
      if (pose_expected.size() == 0) begin
        $error("result beat with no pose pending");
        failures++;
      end else begin
        want = pose_expected.pop_front();
        if (out_data.position_x !== want.position_x) begin
          $error("position_x: expected %0d, got %0d", want.position_x, out_data.position_x);
          failures++;
        end
        if (out_data.position_y !== want.position_y) begin
          $error("position_y: expected %0d, got %0d", want.position_y, out_data.position_y);
          failures++;
        end
        if (out_data.position_z !== want.position_z) begin
          $error("position_z: expected %0d, got %0d", want.position_z, out_data.position_z);
          failures++;
        end
        if (out_data.quat_z !== want.quat_z) begin
          $error("quat_z: expected %0d, got %0d", want.quat_z, out_data.quat_z);
          failures++;
        end
        if (out_data.quat_w !== want.quat_w) begin
          $error("quat_w: expected %0d, got %0d", want.quat_w, out_data.quat_w);
          failures++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("** planar_odometry_integrator: FAILED **");
        $finish;
      end
    end
  end

  task automatic send_command(input in_t cmd);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= cmd;
    do @(posedge clk); while (!in_ready);
    pose_expected.push_back(advance_pose(cmd));
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pose_expected.size() != 0) @(posedge clk);
  endtask

  task automatic set_regs(input logic [15:0] step, input logic [31:0] alt);
    cfg_we <= 1'b1;
    cfg_index <= REG_STEP_TIME;
    cfg_data <= {16'd0, step};
    @(posedge clk);
    step_q16 = step;
    cfg_index <= REG_ALTITUDE;
    cfg_data <= alt;
    @(posedge clk);
    height_q16 = alt;
    cfg_we <= 1'b0;
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_gap_pct = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  function automatic logic [15:0] pick_speed();
    case ($urandom_range(9))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic in_t random_command();
    in_t cmd;
    cmd.speed_forward = pick_speed();
    cmd.speed_lateral = pick_speed();
    cmd.yaw_rate = pick_speed();
    return cmd;
  endfunction

  function automatic in_t make_command(input int fwd, input int lat, input int yaw);
    in_t cmd;
    cmd.speed_forward = 16'(fwd);
    cmd.speed_lateral = 16'(lat);
    cmd.yaw_rate = 16'(yaw);
    return cmd;
  endfunction

  task automatic test_reset_defaults();
    send_command(make_command(0, 0, 0));
    send_command(make_command(32767, 0, 0));
    send_command(make_command(-32768, 0, 0));
    send_command(make_command(0, 32767, 0));
    send_command(make_command(0, -32768, 0));
    send_command(make_command(0, 0, 32767));
    send_command(make_command(0, 0, -32768));
    send_command(make_command(-1, -1, -1));
    settle();
  endtask

  task automatic test_register_extremes();
    // zero step: pose must not move at all
    set_regs(16'h0000, 32'h8000_0000);
    send_command(make_command(32767, 32767, 32767));
    send_command(make_command(-32768, -32768, -32768));
    settle();
    set_regs(16'hFFFF, 32'h7FFF_FFFF);
    send_command(make_command(32767, -32768, 4096));
    send_command(make_command(-32768, 32767, -4096));
    settle();
  endtask

  task automatic test_heading_wrap();
    set_regs(16'hFFFF, 32'h0000_0000);
    repeat (4) send_command(make_command(256, -256, 32767));
    repeat (4) send_command(make_command(-256, 256, -32768));
    settle();
  endtask

  task automatic test_random_motion(input int count, input logic [15:0] step,
                                    input logic [31:0] alt);
    set_regs(step, alt);
    repeat (count) send_command(random_command());
    settle();
  endtask

  // near-full speed with almost no turning drives at least one axis into its clamp
  task automatic test_saturation(input int count, input bit reverse);
    in_t cmd;
    set_regs(16'hFFFF, $urandom);
    repeat (count) begin
      if ($urandom_range(9) == 0) begin
        cmd = random_command();
      end else begin
        cmd.speed_forward = reverse ? 16'(-32768 + $urandom_range(15))
                                    : 16'(32767 - $urandom_range(15));
        cmd.speed_lateral = reverse ? 16'(-32768 + $urandom_range(15))
                                    : 16'(32767 - $urandom_range(15));
        cmd.yaw_rate = 16'(int'($urandom_range(4)) - 2);
      end
      send_command(cmd);
    end
    settle();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_register_extremes();
    test_heading_wrap();

    set_idling(18, 46);
    test_random_motion(300, 16'($urandom), $urandom);
    test_random_motion(250, 16'($urandom_range(64)), $urandom);
    test_saturation(350, 1'b0);

    set_idling(46, 18);
    test_saturation(600, 1'b1);
    test_random_motion(150, 16'($urandom_range(65535, 32768)), 32'h8000_0000);

    set_idling(0, 0);
    test_random_motion(250, 16'hFFFF, 32'h7FFF_FFFF);

    repeat (100) @(posedge clk);
    if (failures == 0) begin
      $display("** planar_odometry_integrator: PASSED **");
    end else begin
      $display("** planar_odometry_integrator: FAILED **");
    end
    $finish;
  end

endmodule

// ===== planar_odometry_integrator.f =====
hdl/poi_pkg.sv
hdl/poi_mul.sv
hdl/poi_cordic.sv
hdl/planar_odometry_integrator.sv
verif/tb_top.sv
